FILE: hw/rtl/tlc_pkg.sv
// shared types and constants for the traffic light controller
package tlc_pkg;

  localparam int TIME_BITS = 32;
  localparam int SAMPLE_BITS = 12;
  localparam int LUX_BITS = 10;
  localparam int SECS_BITS = 8;
  localparam int TICK_BITS = 16;
  localparam int IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int STREAM_BITS = 16;

  localparam logic [LUX_BITS-1:0] LUX_FULL = 10'd1000;
  localparam logic [SAMPLE_BITS:0] ADC_FULL = 13'd4095;

  localparam logic [SECS_BITS-1:0] GREEN_SECONDS_RST = 8'd7;
  localparam logic [SECS_BITS-1:0] YELLOW_SECONDS_RST = 8'd3;
  localparam logic [SECS_BITS-1:0] RED_SECONDS_RST = 8'd5;
  localparam logic [LUX_BITS-1:0] DARK_LUX_RST = 10'd300;
  localparam logic [TICK_BITS-1:0] SECOND_TICKS_RST = 16'd1000;
  localparam logic [TICK_BITS-1:0] BLINK_TICKS_RST = 16'd500;
  localparam logic [TICK_BITS-1:0] BUTTON_TICKS_RST = 16'd50;

  typedef enum logic [IDX_BITS-1:0] {
    REG_GREEN_SECONDS  = 3'd0,
    REG_YELLOW_SECONDS = 3'd1,
    REG_RED_SECONDS    = 3'd2,
    REG_DARK_LUX       = 3'd3,
    REG_SECOND_TICKS   = 3'd4,
    REG_BLINK_TICKS    = 3'd5,
    REG_BUTTON_TICKS   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_GREEN  = 2'd0,
    PH_YELLOW = 2'd1,
    PH_RED    = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_SHOW  = 2'd1,
    ACT_CLEAR = 2'd2
  } disp_act_t;

  typedef struct packed {
    logic [SECS_BITS-1:0] green_seconds;
    logic [SECS_BITS-1:0] yellow_seconds;
    logic [SECS_BITS-1:0] red_seconds;
    logic [LUX_BITS-1:0]  dark_lux;
    logic [TICK_BITS-1:0] second_ticks;
    logic [TICK_BITS-1:0] blink_ticks;
    logic [TICK_BITS-1:0] button_ticks;
  } cfg_t;

  // packed so that red_on lands in the lowest bit
  typedef struct packed {
    logic [SECS_BITS-1:0] display_value;
    disp_act_t            display_action;
    logic                 hold_lamp_on;
    logic                 green_on;
    logic                 yellow_on;
    logic                 red_on;
  } result_t;

  localparam int RESULT_BITS = $bits(result_t);

endpackage

FILE: hw/rtl/traffic_light_controller_night_blink.sv
// top level of the traffic light controller with night blinking
// Each transfer on the s_axis channel is one millisecond tick carrying the
// light sample and the button level; each tick yields exactly one transfer
// on the m_axis channel with the lamp levels and the display command.
// The cfg channel writes one of seven registers by index (always ready);
// write it only while no tick is in flight.
// The tick is captured in an input register, processed combinationally by the
// lux converter and the timer/phase logic, and lands in an output register:
// m_axis_tvalid rises once the tick moves from the input register into the
// output register, and the output transfer follows when the receiver is ready.
// Throughput is one tick per cycle while the receiver is ready; the input
// register takes a new tick when empty or when its tick moves on to the output
// register in the same cycle. When the receiver stalls, the result holds in the
// output register, the next tick in the input register, and s_axis_tready drops.
// Synchronous reset empties both registers, restores register defaults,
// clears all timestamps and starts in the green phase with green lit.
module traffic_light_controller_night_blink (
  input  logic                               clk,
  input  logic                               rst,
  // [11:0] light_sample, [12] button_pressed
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [tlc_pkg::STREAM_BITS-1:0]    s_axis_tdata,
  // [0] red_on, [1] yellow_on, [2] green_on, [3] hold_lamp_on,
  // [5:4] display_action, [13:6] display_value
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [tlc_pkg::STREAM_BITS-1:0]    m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [tlc_pkg::IDX_BITS-1:0]       cfg_index,
  input  logic [tlc_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import tlc_pkg::*;

  cfg_t                   cfg;
  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   in_button;
  logic                   advance;
  logic [LUX_BITS-1:0]    lux;
  result_t                result;
  result_t                out_result;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tdata  = {(STREAM_BITS - RESULT_BITS)'(0), out_result};

  tlc_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  tlc_lux u_lux (
    .sample (in_sample),
    .lux    (lux)
  );

  tlc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .lux            (lux),
    .button_pressed (in_button),
    .cfg            (cfg),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
      in_button <= s_axis_tdata[SAMPLE_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

endmodule

FILE: hw/rtl/tlc_cfg_regs.sv
// configuration register file
module tlc_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [tlc_pkg::IDX_BITS-1:0]       wr_index,
  input  logic [tlc_pkg::CFG_DATA_BITS-1:0]  wr_data,
  output tlc_pkg::cfg_t                      cfg
);
  import tlc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.green_seconds  <= GREEN_SECONDS_RST;
      cfg.yellow_seconds <= YELLOW_SECONDS_RST;
      cfg.red_seconds    <= RED_SECONDS_RST;
      cfg.dark_lux       <= DARK_LUX_RST;
      cfg.second_ticks   <= SECOND_TICKS_RST;
      cfg.blink_ticks    <= BLINK_TICKS_RST;
      cfg.button_ticks   <= BUTTON_TICKS_RST;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_GREEN_SECONDS:  cfg.green_seconds  <= wr_data[SECS_BITS-1:0];
        REG_YELLOW_SECONDS: cfg.yellow_seconds <= wr_data[SECS_BITS-1:0];
        REG_RED_SECONDS:    cfg.red_seconds    <= wr_data[SECS_BITS-1:0];
        REG_DARK_LUX:       cfg.dark_lux       <= wr_data[LUX_BITS-1:0];
        REG_SECOND_TICKS:   cfg.second_ticks   <= wr_data[TICK_BITS-1:0];
        REG_BLINK_TICKS:    cfg.blink_ticks    <= wr_data[TICK_BITS-1:0];
        REG_BUTTON_TICKS:   cfg.button_ticks   <= wr_data[TICK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/tlc_lux.sv
// light sample to lux conversion: 1000 - floor(sample * 1000 / 4095)
module tlc_lux (
  input  logic [tlc_pkg::SAMPLE_BITS-1:0] sample,
  output logic [tlc_pkg::LUX_BITS-1:0]    lux
);
  import tlc_pkg::*;

  localparam int PROD_BITS = SAMPLE_BITS + LUX_BITS;

  logic [PROD_BITS-1:0]   prod;
  logic [LUX_BITS-1:0]    q_low;
  logic [SAMPLE_BITS:0]   rem;
  logic [LUX_BITS-1:0]    quot;

  // divide by 4095 as floor(p / 4096) plus one correction step
  always_comb begin
    prod  = PROD_BITS'(sample) * PROD_BITS'(LUX_FULL);
    q_low = prod[PROD_BITS-1:SAMPLE_BITS];
    rem   = {1'b0, prod[SAMPLE_BITS-1:0]} + (SAMPLE_BITS+1)'(q_low);
    quot  = (rem >= ADC_FULL) ? q_low + LUX_BITS'(1) : q_low;
    lux   = LUX_FULL - quot;
  end

endmodule

FILE: hw/rtl/tlc_core.sv
// per-tick timers, phase sequencer and lamp state
module tlc_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [tlc_pkg::LUX_BITS-1:0]  lux,
  input  logic                          button_pressed,
  input  tlc_pkg::cfg_t                 cfg,
  output tlc_pkg::result_t              result
);
  import tlc_pkg::*;

  logic [TIME_BITS-1:0] time_now, time_now_next;
  logic [TIME_BITS-1:0] normal_stamp, normal_stamp_next;
  logic [TIME_BITS-1:0] quiet_stamp, quiet_stamp_next;
  logic [TIME_BITS-1:0] blink_stamp, blink_stamp_next;
  logic [TIME_BITS-1:0] button_stamp, button_stamp_next;
  phase_t               phase, phase_next;
  logic [SECS_BITS-1:0] seconds_left, seconds_left_next;
  logic                 blink_level, blink_level_next;
  logic                 display_off, display_off_next;
  logic                 lamp_red, lamp_red_next;
  logic                 lamp_yellow, lamp_yellow_next;
  logic                 lamp_green, lamp_green_next;
  logic                 lamp_hold, lamp_hold_next;

  logic                 button_due, blink_due, second_due;
  logic [TIME_BITS-1:0] second_stamp;

  always_comb begin
    time_now_next     = time_now + TIME_BITS'(1);
    normal_stamp_next = normal_stamp;
    quiet_stamp_next  = quiet_stamp;
    blink_stamp_next  = blink_stamp;
    button_stamp_next = button_stamp;
    phase_next        = phase;
    seconds_left_next = seconds_left;
    blink_level_next  = blink_level;
    display_off_next  = display_off;
    lamp_red_next     = lamp_red;
    lamp_yellow_next  = lamp_yellow;
    lamp_green_next   = lamp_green;
    lamp_hold_next    = lamp_hold;
    result            = '0;
    result.display_action = ACT_NONE;

    button_due = (time_now_next - button_stamp) >= TIME_BITS'(cfg.button_ticks);
    if (button_pressed && button_due) begin
      button_stamp_next = time_now_next;
      display_off_next  = !display_off;
    end

    blink_due    = (time_now_next - blink_stamp) >= TIME_BITS'(cfg.blink_ticks);
    second_stamp = display_off_next ? quiet_stamp : normal_stamp;
    second_due   = (time_now_next - second_stamp) >= TIME_BITS'(cfg.second_ticks);

    if (lux < cfg.dark_lux) begin
      if (blink_due) begin
        blink_stamp_next = time_now_next;
        blink_level_next = !blink_level;
        lamp_yellow_next = !blink_level;
      end
      lamp_green_next       = 1'b0;
      lamp_red_next         = 1'b0;
      result.display_action = ACT_CLEAR;
    end else begin
      lamp_hold_next = display_off_next;
      if (second_due) begin
        if (display_off_next) begin
          quiet_stamp_next = time_now_next;
        end else begin
          normal_stamp_next = time_now_next;
        end
        if (seconds_left != '0) begin
          seconds_left_next = seconds_left - SECS_BITS'(1);
        end else begin
          case (phase)
            PH_GREEN: begin
              phase_next        = PH_YELLOW;
              seconds_left_next = cfg.yellow_seconds;
            end
            PH_YELLOW: begin
              phase_next        = PH_RED;
              seconds_left_next = cfg.red_seconds;
            end
            default: begin
              phase_next        = PH_GREEN;
              seconds_left_next = cfg.green_seconds;
            end
          endcase
        end
        if (display_off_next) begin
          result.display_action = ACT_CLEAR;
        end else begin
          result.display_action = ACT_SHOW;
          result.display_value  = seconds_left_next;
        end
      end
      lamp_green_next  = (phase_next == PH_GREEN);
      lamp_yellow_next = (phase_next == PH_YELLOW);
      lamp_red_next    = (phase_next != PH_GREEN) && (phase_next != PH_YELLOW);
    end

    result.red_on       = lamp_red_next;
    result.yellow_on    = lamp_yellow_next;
    result.green_on     = lamp_green_next;
    result.hold_lamp_on = lamp_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      time_now     <= '0;
      normal_stamp <= '0;
      quiet_stamp  <= '0;
      blink_stamp  <= '0;
      button_stamp <= '0;
      phase        <= PH_GREEN;
      seconds_left <= GREEN_SECONDS_RST;
      blink_level  <= 1'b0;
      display_off  <= 1'b0;
      lamp_red     <= 1'b0;
      lamp_yellow  <= 1'b0;
      lamp_green   <= 1'b1;
      lamp_hold    <= 1'b0;
    end else if (step) begin
      time_now     <= time_now_next;
      normal_stamp <= normal_stamp_next;
      quiet_stamp  <= quiet_stamp_next;
      blink_stamp  <= blink_stamp_next;
      button_stamp <= button_stamp_next;
      phase        <= phase_next;
      seconds_left <= seconds_left_next;
      blink_level  <= blink_level_next;
      display_off  <= display_off_next;
      lamp_red     <= lamp_red_next;
      lamp_yellow  <= lamp_yellow_next;
      lamp_green   <= lamp_green_next;
      lamp_hold    <= lamp_hold_next;
    end
  end

endmodule

FILE: verif/tb_traffic_light_controller_night_blink.sv
// testbench for the traffic light controller with night blinking and display-off mode
module tb_traffic_light_controller_night_blink;
  timeunit 1ns;
  timeprecision 1ps;

  import tlc_pkg::*;

  class lamp_predictor;
    cfg_t            cfg;
    logic [31:0]     now, normal_stamp, quiet_stamp, blink_stamp, button_stamp;
    phase_t          phase;
    logic [8:0]      secs_left;
    logic            blink_level, off_mode;
    logic            red, yellow, green, hold;
    result_t         expected_lamps[$];
    int unsigned     bad;

    function new();
      cfg.green_seconds  = GREEN_SECONDS_RST;
      cfg.yellow_seconds = YELLOW_SECONDS_RST;
      cfg.red_seconds    = RED_SECONDS_RST;
      cfg.dark_lux       = DARK_LUX_RST;
      cfg.second_ticks   = SECOND_TICKS_RST;
      cfg.blink_ticks    = BLINK_TICKS_RST;
      cfg.button_ticks   = BUTTON_TICKS_RST;
      now = '0;
      normal_stamp = '0;
      quiet_stamp = '0;
      blink_stamp = '0;
      button_stamp = '0;
      phase = PH_GREEN;
      secs_left = {1'b0, GREEN_SECONDS_RST};
      blink_level = 1'b0;
      off_mode = 1'b0;
      red = 1'b0;
      yellow = 1'b0;
      green = 1'b1;
      hold = 1'b0;
      bad = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        REG_GREEN_SECONDS:  cfg.green_seconds = val[SECS_BITS-1:0];
        REG_YELLOW_SECONDS: cfg.yellow_seconds = val[SECS_BITS-1:0];
        REG_RED_SECONDS:    cfg.red_seconds = val[SECS_BITS-1:0];
        REG_DARK_LUX:       cfg.dark_lux = val[LUX_BITS-1:0];
        REG_SECOND_TICKS:   cfg.second_ticks = val[TICK_BITS-1:0];
        REG_BLINK_TICKS:    cfg.blink_ticks = val[TICK_BITS-1:0];
        REG_BUTTON_TICKS:   cfg.button_ticks = val[TICK_BITS-1:0];
        default: ;
      endcase
    endfunction

    function bit elapsed(logic [31:0] stamp, logic [TICK_BITS-1:0] interval);
      return (now - stamp) >= {16'd0, interval};
    endfunction

    function void count_down();
      if (secs_left != 0) begin
        secs_left = secs_left - 1'b1;
        return;
      end
      case (phase)
        PH_GREEN: begin
          phase = PH_YELLOW;
          secs_left = {1'b0, cfg.yellow_seconds};
        end
        PH_YELLOW: begin
          phase = PH_RED;
          secs_left = {1'b0, cfg.red_seconds};
        end
        default: begin
          phase = PH_GREEN;
          secs_left = {1'b0, cfg.green_seconds};
        end
      endcase
    endfunction

    function void note_tick(logic [SAMPLE_BITS-1:0] sample, logic pressed);
      int unsigned lux;
      bit          fired;
      result_t     r;
      r = '0;
      now = now + 1'b1;
      lux = 32'd1000 - ({20'd0, sample} * 32'd1000) / 32'd4095;
      if (pressed && elapsed(button_stamp, cfg.button_ticks)) begin
        button_stamp = now;
        off_mode = !off_mode;
      end
      r.display_action = ACT_NONE;
      if (lux < {22'd0, cfg.dark_lux}) begin
        if (elapsed(blink_stamp, cfg.blink_ticks)) begin
          blink_stamp = now;
          blink_level = !blink_level;
          yellow = blink_level;
        end
        green = 1'b0;
        red = 1'b0;
        r.display_action = ACT_CLEAR;
      end else begin
        hold = off_mode;
        if (off_mode) begin
          fired = elapsed(quiet_stamp, cfg.second_ticks);
          if (fired) quiet_stamp = now;
        end else begin
          fired = elapsed(normal_stamp, cfg.second_ticks);
          if (fired) normal_stamp = now;
        end
        if (fired) begin
          count_down();
          if (off_mode) begin
            r.display_action = ACT_CLEAR;
          end else begin
            r.display_action = ACT_SHOW;
            r.display_value = secs_left[7:0];
          end
        end
        green = (phase == PH_GREEN);
        yellow = (phase == PH_YELLOW);
        red = (phase != PH_GREEN) && (phase != PH_YELLOW);
      end
      r.red_on = red;
      r.yellow_on = yellow;
      r.green_on = green;
      r.hold_lamp_on = hold;
      expected_lamps.push_back(r);
    endfunction

    function void cmp(string field, int unsigned exp, int unsigned act);
      if (exp != act) begin
        $display("%0t: %s expected %0d, actual %0d", $time, field, exp, act);
        bad++;
      end
    endfunction

    function void check_lamps(logic [STREAM_BITS-1:0] tdata);
      result_t act, exp;
      act = result_t'(tdata[RESULT_BITS-1:0]);
      if (expected_lamps.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, tdata);
        bad++;
        return;
      end
      exp = expected_lamps.pop_front();
      cmp("red_on", 32'(exp.red_on), 32'(act.red_on));
      cmp("yellow_on", 32'(exp.yellow_on), 32'(act.yellow_on));
      cmp("green_on", 32'(exp.green_on), 32'(act.green_on));
      cmp("hold_lamp_on", 32'(exp.hold_lamp_on), 32'(act.hold_lamp_on));
      cmp("display_action", 32'(exp.display_action), 32'(act.display_action));
      cmp("display_value", 32'(exp.display_value), 32'(act.display_value));
    endfunction

    function int pending();
      return expected_lamps.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [STREAM_BITS-1:0]   s_axis_tdata = '0;  // [11:0] light_sample, [12] button_pressed
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [STREAM_BITS-1:0]   m_axis_tdata;  // [0] red, [1] yellow, [2] green, [3] hold,
                                           // [5:4] display_action, [13:6] display_value
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [IDX_BITS-1:0]      cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  lamp_predictor lamp_book;
  bit            calm_send, calm_recv;
  bit            day_run = 1'b1;
  bit            held = 1'b0;

  traffic_light_controller_night_blink i_dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #1ms;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_tick(logic [SAMPLE_BITS-1:0] sample, logic pressed);
    int gap;
    gap = calm_send ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, pressed, sample};
    do @(posedge clk); while (!s_axis_tready);
    lamp_book.note_tick(sample, pressed);
  endtask

  // no tick in flight once this returns
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (lamp_book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    lamp_book.set_reg(idx, val);
  endtask

  task automatic write_all(int g, int y, int r, int dark, int sec, int blink, int btn);
    drain();
    write_reg(REG_GREEN_SECONDS, CFG_DATA_BITS'(g));
    write_reg(REG_YELLOW_SECONDS, CFG_DATA_BITS'(y));
    write_reg(REG_RED_SECONDS, CFG_DATA_BITS'(r));
    write_reg(REG_DARK_LUX, CFG_DATA_BITS'(dark));
    write_reg(REG_SECOND_TICKS, CFG_DATA_BITS'(sec));
    write_reg(REG_BLINK_TICKS, CFG_DATA_BITS'(blink));
    write_reg(REG_BUTTON_TICKS, CFG_DATA_BITS'(btn));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // runs of day and night samples with held button stretches, plus noise
  task automatic random_tick();
    logic [SAMPLE_BITS-1:0] sample;
    if ($urandom_range(0, 9) == 0) day_run = !day_run;
    if ($urandom_range(0, 5) == 0) held = !held;
    if ($urandom_range(0, 9) < 3) begin
      sample = SAMPLE_BITS'($urandom_range(0, 4095));
    end else if (day_run) begin
      sample = SAMPLE_BITS'($urandom_range(0, 1800));
    end else begin
      sample = SAMPLE_BITS'($urandom_range(2300, 4095));
    end
    send_tick(sample, ($urandom_range(0, 9) == 0) ? !held : held);
  endtask

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = calm_recv ? 0 : $urandom_range(0, 12);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
      lamp_book.check_lamps(m_axis_tdata);
    end
  end

  initial begin
    lamp_book = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // register defaults, extremes of the sample and the button
    calm_send = 1'b0;
    calm_recv = 1'b1;
    send_tick(12'd0, 1'b0);
    send_tick(12'd4095, 1'b0);
    send_tick(12'd4095, 1'b1);
    send_tick(12'd2870, 1'b0);
    send_tick(12'd2871, 1'b1);
    send_tick(12'd0, 1'b1);

    // fast timers, zero green preset, zero button interval
    write_all(0, 1, 2, 300, 1, 1, 0);
    calm_send = 1'b1;
    calm_recv = 1'b0;
    repeat (5) send_tick(12'd100, 1'b0);
    send_tick(12'd0, 1'b1);
    send_tick(12'd0, 1'b1);
    send_tick(12'd1000, 1'b1);
    send_tick(12'd2870, 1'b0);
    send_tick(12'd2871, 1'b0);
    send_tick(12'd4095, 1'b0);
    send_tick(12'd3500, 1'b1);
    send_tick(12'd4095, 1'b0);
    send_tick(12'd2000, 1'b0);
    send_tick(12'd0, 1'b0);
    send_tick(12'd0, 1'b1);
    send_tick(12'd50, 1'b0);
    send_tick(12'd50, 1'b0);

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        1: write_all(255, 255, 255, 0, 1, 65535, 65535);
        2: write_all($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                     1000, 0, 0, 0);
        3: write_all($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3),
                     $urandom_range(0, 1000), 65535, 1, 1);
        default: write_all($urandom_range(0, 4), $urandom_range(0, 4), $urandom_range(0, 4),
                           $urandom_range(0, 1000), $urandom_range(1, 3),
                           $urandom_range(1, 3), $urandom_range(0, 4));
      endcase
      calm_send = ($urandom_range(0, 3) == 0);
      calm_recv = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 48; n++) begin
        if (ph == 3 && n == 24) drain();
        random_tick();
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (lamp_book.bad == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
